@@ src/jts_pkg.sv @@
// jts_pkg: shared types, constants and helpers of the JSON token scanner.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none
package jts_pkg;

  // Width of the byte position counter; token positions go out in 32 bits.
  localparam int POS_W = 32;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_MAX_M1 = {{(POS_W-1){1'b1}}, 1'b0};

  // Queue depths (powers of two).
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = $clog2(OQ_DEPTH);

  // Token kinds.
  localparam logic [3:0] KIND_END    = 4'd0;
  localparam logic [3:0] KIND_LBRACK = 4'd1;
  localparam logic [3:0] KIND_RBRACK = 4'd2;
  localparam logic [3:0] KIND_LBRACE = 4'd3;
  localparam logic [3:0] KIND_RBRACE = 4'd4;
  localparam logic [3:0] KIND_COLON  = 4'd5;
  localparam logic [3:0] KIND_COMMA  = 4'd6;
  localparam logic [3:0] KIND_STRING = 4'd7;
  localparam logic [3:0] KIND_NUMBER = 4'd8;
  localparam logic [3:0] KIND_TRUE   = 4'd9;
  localparam logic [3:0] KIND_ERROR  = 4'd12;

  // Characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_N = 8'h6e;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  // Literal selectors and spelled-out text, first character in the top byte.
  localparam logic [1:0] LIT_W_TRUE  = 2'd0;
  localparam logic [1:0] LIT_W_FALSE = 2'd1;
  localparam logic [1:0] LIT_W_NULL  = 2'd2;
  localparam logic [39:0] LIT_TRUE_S  = {"true", 8'h00};
  localparam logic [39:0] LIT_FALSE_S = "false";
  localparam logic [39:0] LIT_NULL_S  = {"null", 8'h00};

  // Byte classes from the front end.
  typedef enum logic [3:0] {
    CLS_WS, CLS_END, CLS_PUNCT, CLS_QUOTE, CLS_MINUS, CLS_PLUS,
    CLS_DIGIT, CLS_DOT, CLS_EXP, CLS_LIT, CLS_OTHER
  } cls_t;

  // One classified byte on its way to the lexer.
  typedef struct packed {
    logic [7:0]       text_byte;
    cls_t             cls;
    logic [3:0]       pkind;     // kind for punctuation bytes
    logic [POS_W-1:0] pos;
    logic [POS_W:0]   pos_p1;    // pos + 1, not saturated
    logic             at_max;    // pos is saturated
  } cmd_t;

  // One token as it leaves the block.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } tok_t;

  // Up to two tokens written into the result queue in one cycle.
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } tok_wr_t;

  function automatic logic [31:0] to_out32(logic [POS_W:0] v);
    logic [64:0] w;
    w = 65'(v);
    return w[31:0];
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] w);
    return (w == LIT_W_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] w, logic [2:0] i);
    logic [39:0] s;
    logic [7:0]  ch;
    s = (w == LIT_W_TRUE) ? LIT_TRUE_S : (w == LIT_W_FALSE) ? LIT_FALSE_S : LIT_NULL_S;
    case (i)
      3'd0:    ch = s[39:32];
      3'd1:    ch = s[31:24];
      3'd2:    ch = s[23:16];
      3'd3:    ch = s[15:8];
      3'd4:    ch = s[7:0];
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

@@ src/json_token_scanner.sv @@
// json_token_scanner: top level of the byte-serial JSON tokenizer.
// Uses jts_pkg, jts_front, jts_cmd_fifo, jts_lexer and jts_tok_queue.
//
//  channel   ports                                      handshake
//  --------  -----------------------------------------  -------------------------
//  input     in_text_byte                               push && !full takes item
//  result    out_token_kind/start/length/last_of_run    pop && !empty takes item
//
// One text byte per cycle while the result queue has room: the lexer state machine
// takes one classified byte per cycle when the result queue has room for two tokens
// and writes up to two tokens into it. A byte's tokens reach the result ports
// through two registered queues (classify into the byte queue, lex into the result
// queue); the lexer can stall between them. A byte that closes a number, literal
// or unterminated string can give two tokens, which drain one per cycle while pop is held.
// Reset (rst_n low, synchronous) clears position, mode and both queues.
// A stalled result side fills the result queue, then the byte queue, then
// full rises; neither side waits on the other while there is queue space.
`default_nettype none
module json_token_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_text_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       out_token_kind,
  output logic [31:0]      out_token_start,
  output logic [31:0]      out_token_length,
  output logic             out_last_of_run
);

  jts_pkg::cmd_t    fe_cmd, lx_cmd;
  logic             fe_wr, lx_valid, lx_pop, oq_room;
  jts_pkg::tok_wr_t lx_wr;
  jts_pkg::tok_t    oq_head;

  // Front end: position counter and byte classes.
  jts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .text_byte (in_text_byte),
    .full      (full),
    .cmd       (fe_cmd),
    .cmd_wr    (fe_wr)
  );

  // Decoupling queue: lets the lexer stall without stopping intake.
  jts_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fe_wr),
    .wr_data  (fe_cmd),
    .full     (full),
    .rd_en    (lx_pop),
    .rd_valid (lx_valid),
    .rd_data  (lx_cmd)
  );

  // Back end: token state machine, runs only with room for two tokens.
  jts_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (lx_valid),
    .cmd       (lx_cmd),
    .cmd_pop   (lx_pop),
    .room      (oq_room),
    .wr        (lx_wr)
  );

  // Result queue; its head drives the result ports.
  jts_tok_queue u_tok_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (lx_wr),
    .room  (oq_room),
    .pop   (pop),
    .empty (empty),
    .head  (oq_head)
  );

  assign out_token_kind = oq_head.kind;
  assign out_token_start = oq_head.start;
  assign out_token_length = oq_head.len;
  assign out_last_of_run = oq_head.last;

endmodule
`default_nettype wire

@@ src/jts_front.sv @@
// jts_front: byte position counter and byte classifier.
// Uses jts_pkg; feeds jts_cmd_fifo.
`default_nettype none
module jts_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire logic [7:0]      text_byte,
  input  wire logic            full,
  output jts_pkg::cmd_t        cmd,
  output logic                 cmd_wr
);

  logic [jts_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [jts_pkg::POS_W:0]   pos_p1;
  logic                      at_max;

  assign cmd_wr = push && !full;
  assign at_max = (pos_r == jts_pkg::POS_MAX);
  assign pos_p1 = {1'b0, pos_r} + {{jts_pkg::POS_W{1'b0}}, 1'b1};
  assign pos_nxt = at_max ? pos_r : pos_p1[jts_pkg::POS_W-1:0];

  always_comb begin
    cmd.text_byte = text_byte;
    cmd.pos = pos_r;
    cmd.pos_p1 = pos_p1;
    cmd.at_max = at_max;
    cmd.pkind = jts_pkg::KIND_ERROR;
    cmd.cls = jts_pkg::CLS_OTHER;
    case (text_byte)
      jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_LF,
      jts_pkg::CH_VT, jts_pkg::CH_FF, jts_pkg::CH_CR: cmd.cls = jts_pkg::CLS_WS;
      jts_pkg::CH_NUL:   cmd.cls = jts_pkg::CLS_END;
      jts_pkg::CH_LBRACK: begin
        cmd.cls = jts_pkg::CLS_PUNCT;
        cmd.pkind = jts_pkg::KIND_LBRACK;
      end
      jts_pkg::CH_RBRACK: begin
        cmd.cls = jts_pkg::CLS_PUNCT;
        cmd.pkind = jts_pkg::KIND_RBRACK;
      end
      jts_pkg::CH_LBRACE: begin
        cmd.cls = jts_pkg::CLS_PUNCT;
        cmd.pkind = jts_pkg::KIND_LBRACE;
      end
      jts_pkg::CH_RBRACE: begin
        cmd.cls = jts_pkg::CLS_PUNCT;
        cmd.pkind = jts_pkg::KIND_RBRACE;
      end
      jts_pkg::CH_COLON: begin
        cmd.cls = jts_pkg::CLS_PUNCT;
        cmd.pkind = jts_pkg::KIND_COLON;
      end
      jts_pkg::CH_COMMA: begin
        cmd.cls = jts_pkg::CLS_PUNCT;
        cmd.pkind = jts_pkg::KIND_COMMA;
      end
      jts_pkg::CH_QUOTE: cmd.cls = jts_pkg::CLS_QUOTE;
      jts_pkg::CH_MINUS: cmd.cls = jts_pkg::CLS_MINUS;
      jts_pkg::CH_PLUS:  cmd.cls = jts_pkg::CLS_PLUS;
      jts_pkg::CH_DOT:   cmd.cls = jts_pkg::CLS_DOT;
      jts_pkg::CH_LOWER_E, jts_pkg::CH_UPPER_E: cmd.cls = jts_pkg::CLS_EXP;
      jts_pkg::CH_LOWER_T, jts_pkg::CH_LOWER_F,
      jts_pkg::CH_LOWER_N: cmd.cls = jts_pkg::CLS_LIT;
      default: begin
        if (text_byte >= jts_pkg::CH_0 && text_byte <= jts_pkg::CH_9) begin
          cmd.cls = jts_pkg::CLS_DIGIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd_wr) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/jts_cmd_fifo.sv @@
// jts_cmd_fifo: short queue of classified bytes between front end and lexer.
// Uses jts_pkg.
`default_nettype none
module jts_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  jts_pkg::cmd_t      wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output logic               rd_valid,
  output jts_pkg::cmd_t      rd_data
);

  jts_pkg::cmd_t mem_r [jts_pkg::CQ_DEPTH];
  logic [jts_pkg::CQ_AW-1:0] wptr_r, rptr_r;
  logic [jts_pkg::CQ_AW:0]   cnt_r;
  logic                      do_rd;

  assign full = (cnt_r == (jts_pkg::CQ_AW+1)'(jts_pkg::CQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data = mem_r[rptr_r];
  assign do_rd = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + jts_pkg::CQ_AW'(1);
      if (do_rd) rptr_r <= rptr_r + jts_pkg::CQ_AW'(1);
      if (wr_en && !do_rd) cnt_r <= cnt_r + (jts_pkg::CQ_AW+1)'(1);
      else if (!wr_en && do_rd) cnt_r <= cnt_r - (jts_pkg::CQ_AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

@@ src/jts_tok_queue.sv @@
// jts_tok_queue: result queue, takes up to two tokens a cycle, gives one per pop.
// Uses jts_pkg.
`default_nettype none
module jts_tok_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  jts_pkg::tok_wr_t   wr,
  output logic               room,   // space for two more tokens
  input  wire logic          pop,
  output logic               empty,
  output jts_pkg::tok_t      head
);

  jts_pkg::tok_t mem_r [jts_pkg::OQ_DEPTH];
  logic [jts_pkg::OQ_AW-1:0] wptr_r, rptr_r, wptr_p1;
  logic [jts_pkg::OQ_AW:0]   cnt_r, n_wr;
  logic                      do_rd;

  assign empty = (cnt_r == '0);
  assign room = (cnt_r <= (jts_pkg::OQ_AW+1)'(jts_pkg::OQ_DEPTH - 2));
  assign head = mem_r[rptr_r];
  assign do_rd = pop && !empty;
  assign wptr_p1 = wptr_r + jts_pkg::OQ_AW'(1);
  assign n_wr = (jts_pkg::OQ_AW+1)'(wr.v0) + (jts_pkg::OQ_AW+1)'(wr.v1);

  always_ff @(posedge clk) begin
    if (wr.v0) mem_r[wptr_r] <= wr.t0;
    if (wr.v1) mem_r[wptr_p1] <= wr.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_r + n_wr[jts_pkg::OQ_AW-1:0];
      if (do_rd) rptr_r <= rptr_r + jts_pkg::OQ_AW'(1);
      cnt_r <= cnt_r + n_wr - (jts_pkg::OQ_AW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

@@ src/jts_lexer.sv @@
// jts_lexer: token state machine, one classified byte per cycle while room is high.
// Uses jts_pkg; reads jts_cmd_fifo, writes jts_tok_queue.
`default_nettype none
module jts_lexer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  jts_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  wire logic          room,
  output jts_pkg::tok_wr_t   wr
);

  typedef enum logic [3:0] {
    M_IDLE, M_STRING, M_LITERAL, M_NSIGN, M_NINT,
    M_NDOT, M_NFRAC, M_NEXPE, M_NEXPS, M_NEXP
  } mode_t;

  mode_t                     mode_r, mode_nxt, num_nx;
  logic [1:0]                which_r, which_nxt, w_eff;
  logic [2:0]                idx_r, idx_nxt, idx_p1;
  logic [jts_pkg::POS_W-1:0] start_r, start_nxt, start_m1_r, start_m1_nxt;

  logic                      accept, ahead;
  logic [jts_pkg::POS_W-1:0] len0;
  logic [jts_pkg::POS_W:0]   len1;

  logic                      f_emit, i_emit, run_idle, num_done;
  logic [3:0]                f_kind, i_kind;
  logic [jts_pkg::POS_W-1:0] f_start;
  logic [jts_pkg::POS_W:0]   f_len;
  jts_pkg::tok_t             tf, ti;

  assign accept = cmd_valid && room;
  assign cmd_pop = accept;

  // Open token length up to this byte, and that plus one.
  assign ahead = (cmd.pos >= start_r);
  assign len0 = ahead ? (cmd.pos - start_r) : '0;
  assign len1 = ahead ? (cmd.pos_p1 - {1'b0, start_r})
                      : {{jts_pkg::POS_W{1'b0}}, 1'b1};

  assign w_eff = (which_r == 2'd3) ? jts_pkg::LIT_W_NULL : which_r;
  assign idx_p1 = idx_r + 3'd1;

  always_comb begin
    num_nx = M_IDLE;
    case (mode_r)
      M_NSIGN: if (cmd.cls == jts_pkg::CLS_DIGIT) num_nx = M_NINT;
      M_NINT: begin
        if (cmd.cls == jts_pkg::CLS_DIGIT) num_nx = M_NINT;
        else if (cmd.cls == jts_pkg::CLS_DOT) num_nx = M_NDOT;
        else if (cmd.cls == jts_pkg::CLS_EXP) num_nx = M_NEXPE;
      end
      M_NDOT: if (cmd.cls == jts_pkg::CLS_DIGIT) num_nx = M_NFRAC;
      M_NFRAC: begin
        if (cmd.cls == jts_pkg::CLS_DIGIT) num_nx = M_NFRAC;
        else if (cmd.cls == jts_pkg::CLS_EXP) num_nx = M_NEXPE;
      end
      M_NEXPE: begin
        if (cmd.cls == jts_pkg::CLS_DIGIT) num_nx = M_NEXP;
        else if (cmd.cls == jts_pkg::CLS_PLUS || cmd.cls == jts_pkg::CLS_MINUS) begin
          num_nx = M_NEXPS;
        end
      end
      M_NEXPS, M_NEXP: if (cmd.cls == jts_pkg::CLS_DIGIT) num_nx = M_NEXP;
      default: num_nx = M_IDLE;
    endcase
  end

  assign num_done = (mode_r == M_NINT) || (mode_r == M_NFRAC) || (mode_r == M_NEXP);

  always_comb begin
    mode_nxt = mode_r;
    which_nxt = which_r;
    idx_nxt = idx_r;
    start_nxt = start_r;
    start_m1_nxt = start_m1_r;
    f_emit = 1'b0;
    f_kind = jts_pkg::KIND_ERROR;
    f_start = start_r;
    f_len = {1'b0, len0};
    run_idle = 1'b0;
    i_emit = 1'b0;
    i_kind = jts_pkg::KIND_ERROR;

    // Close or extend the open token.
    unique case (mode_r)
      M_STRING: begin
        if (cmd.cls == jts_pkg::CLS_QUOTE) begin
          f_emit = 1'b1;
          f_kind = jts_pkg::KIND_STRING;
          mode_nxt = M_IDLE;
        end else if (cmd.cls == jts_pkg::CLS_END) begin
          // unterminated string: error covers the opening quote too
          f_emit = 1'b1;
          f_start = start_m1_r;
          f_len = len1;
          run_idle = 1'b1;
        end
      end
      M_LITERAL: begin
        if (idx_r < jts_pkg::lit_len(w_eff) &&
            cmd.text_byte == jts_pkg::lit_char(w_eff, idx_r)) begin
          idx_nxt = idx_p1;
          if (idx_p1 == jts_pkg::lit_len(w_eff)) begin
            f_emit = 1'b1;
            f_kind = jts_pkg::KIND_TRUE + {2'b00, w_eff};
            f_len = len1;
            mode_nxt = M_IDLE;
          end
        end else begin
          f_emit = 1'b1;
          run_idle = 1'b1;
        end
      end
      M_NSIGN, M_NINT, M_NDOT, M_NFRAC, M_NEXPE, M_NEXPS, M_NEXP: begin
        if (num_nx != M_IDLE) begin
          mode_nxt = num_nx;
        end else begin
          f_emit = 1'b1;
          f_kind = num_done ? jts_pkg::KIND_NUMBER : jts_pkg::KIND_ERROR;
          run_idle = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    // Lex the byte from idle.
    if (run_idle) begin
      mode_nxt = M_IDLE;
      unique case (cmd.cls)
        jts_pkg::CLS_WS: ;
        jts_pkg::CLS_END: begin
          i_emit = 1'b1;
          i_kind = jts_pkg::KIND_END;
        end
        jts_pkg::CLS_PUNCT: begin
          i_emit = 1'b1;
          i_kind = cmd.pkind;
        end
        jts_pkg::CLS_QUOTE: begin
          mode_nxt = M_STRING;
          start_nxt = cmd.at_max ? cmd.pos : cmd.pos_p1[jts_pkg::POS_W-1:0];
          start_m1_nxt = cmd.at_max ? jts_pkg::POS_MAX_M1 : cmd.pos;
        end
        jts_pkg::CLS_MINUS: begin
          mode_nxt = M_NSIGN;
          start_nxt = cmd.pos;
        end
        jts_pkg::CLS_DIGIT: begin
          mode_nxt = M_NINT;
          start_nxt = cmd.pos;
        end
        jts_pkg::CLS_LIT: begin
          mode_nxt = M_LITERAL;
          idx_nxt = 3'd1;
          start_nxt = cmd.pos;
          if (cmd.text_byte == jts_pkg::CH_LOWER_T) which_nxt = jts_pkg::LIT_W_TRUE;
          else if (cmd.text_byte == jts_pkg::CH_LOWER_F) which_nxt = jts_pkg::LIT_W_FALSE;
          else which_nxt = jts_pkg::LIT_W_NULL;
        end
        default: begin
          i_emit = 1'b1;
          i_kind = jts_pkg::KIND_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    tf.kind = f_kind;
    tf.start = jts_pkg::to_out32({1'b0, f_start});
    tf.len = jts_pkg::to_out32(f_len);
    tf.last = !i_emit;
    ti.kind = i_kind;
    ti.start = jts_pkg::to_out32({1'b0, cmd.pos});
    ti.len = 32'd1;
    ti.last = 1'b1;
    wr.v0 = accept && (f_emit || i_emit);
    wr.v1 = accept && f_emit && i_emit;
    wr.t0 = f_emit ? tf : ti;
    wr.t1 = ti;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      which_r <= '0;
      idx_r <= '0;
      start_r <= '0;
      start_m1_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      which_r <= which_nxt;
      idx_r <= idx_nxt;
      start_r <= start_nxt;
      start_m1_r <= start_m1_nxt;
    end
  end

  // No token without a byte taken in the same cycle.
  a_tok_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.v0 || wr.v1) |-> accept)
    else $error("token written without a byte");

  // Two tokens from one byte only when an open token closes.
  a_pair_closes: assert property (@(posedge clk) disable iff (!rst_n)
    wr.v1 |-> (mode_r != M_IDLE))
    else $error("token pair from idle");

  // Mode moves only on a taken byte.
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(mode_r))
    else $error("mode changed without a byte");

  // Inside a literal at least its first letter has matched.
  a_lit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_LITERAL) |-> (idx_r != 3'd0))
    else $error("literal index zero in literal mode");

endmodule
`default_nettype wire
